// ===== hw/rtl/dbfd_pkg.sv =====
`timescale 1ns / 1ps

package dbfd_pkg;

  // Frame geometry: 18 half-bits carry a start bit and eight data bits.
  localparam int HALF_BITS   = 18;
  localparam int COUNT_MAX   = HALF_BITS - 1;
  localparam int DATA_BITS   = HALF_BITS / 2;
  localparam int ADDR_W      = $clog2(HALF_BITS);
  localparam int POS_W       = $clog2(HALF_BITS + 1);
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 16;
  localparam int EDGE_TIME_W = 16;
  localparam int TIME_BITS_DEF = 16;

  // Timing window reset values, microseconds
  localparam logic [CFG_W-1:0] HALF_MIN_RST = 16'd300;
  localparam logic [CFG_W-1:0] HALF_MAX_RST = 16'd550;
  localparam logic [CFG_W-1:0] FULL_MIN_RST = 16'd668;
  localparam logic [CFG_W-1:0] FULL_MAX_RST = 16'd1000;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_EVAL   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_HALF_MIN = 2'd0,
    CFG_HALF_MAX = 2'd1,
    CFG_FULL_MIN = 2'd2,
    CFG_FULL_MAX = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STS_NONE    = 2'd0,
    STS_INVALID = 2'd1,
    STS_DATA    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_TAIL,
    FSM_DONE
  } fsm_e;

  // One memory port request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_req_t;

endpackage

// ===== hw/rtl/dbfd_edge_mem.sv =====
`timescale 1ns / 1ps

module dbfd_edge_mem import dbfd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  mem_req_t             wr_req_i,
  input  logic                 wr_level_i,
  input  logic [TIME_BITS-1:0] wr_time_i,
  input  mem_req_t             rd_req_i,
  output logic                 rd_level_o,
  output logic [TIME_BITS-1:0] rd_time_o
);

  // {level, time} per captured edge; no reset, entries are written before use
  logic [TIME_BITS:0] mem_q [HALF_BITS];
  logic [TIME_BITS:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem_q[wr_req_i.addr] <= {wr_level_i, wr_time_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_data_q <= mem_q[rd_req_i.addr];
    end
  end

  assign rd_level_o = rd_data_q[TIME_BITS];
  assign rd_time_o  = rd_data_q[TIME_BITS-1:0];

endmodule

// ===== hw/rtl/dbfd_frame_check.sv =====
`timescale 1ns / 1ps

module dbfd_frame_check import dbfd_pkg::*; (
  input  logic [HALF_BITS-1:0] stream_i,
  output logic                 ok_o,
  output logic [BYTE_W-1:0]    byte_o
);

  always_comb begin
    logic                 run_err;
    logic                 code_err;
    logic [1:0]           pair;
    logic [DATA_BITS-1:0] word;
    run_err  = 1'b0;
    code_err = 1'b0;
    word     = '0;
    pair     = '0;
    // no three equal half-bits in a row
    for (int k = 0; k < HALF_BITS - 2; k++) begin
      if (stream_i[k +: 3] == 3'b000 || stream_i[k +: 3] == 3'b111) begin
        run_err = 1'b1;
      end
    end
    // Manchester: 01 is a one, 10 a zero, first pair is the start bit
    for (int i = 0; i < DATA_BITS; i++) begin
      pair = stream_i[HALF_BITS - 1 - 2 * i -: 2];
      word[DATA_BITS - 1 - i] = (pair == 2'b01);
      if (pair == 2'b00 || pair == 2'b11) begin
        code_err = 1'b1;
      end
    end
    ok_o   = !run_err && !code_err && word[DATA_BITS-1];
    byte_o = ok_o ? word[BYTE_W-1:0] : '0;
  end

endmodule

// ===== hw/rtl/dali_backward_frame_decoder.sv =====
`timescale 1ns / 1ps

// Record command: busy stays low, so records may come back to back.
// Evaluate command with n stored edges: when n >= 2 the edges are walked with one
// edge-memory read per cycle, through the walk, tail and done states; when n < 2 it
// goes straight to done. busy is high until the strobe cycle. The result cannot be stalled.
// Reset (rst_ni, async, active low) empties the edge store and loads default windows.
module dali_backward_frame_decoder import dbfd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic                   cmd_i,
  input  logic                   edge_level_i,
  input  logic [EDGE_TIME_W-1:0] edge_time_i,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // result strobe
  output logic                   result_valid_o,
  output logic [1:0]             status_o,
  output logic [BYTE_W-1:0]      answer_byte_o
);

  // Gap compare width covers both the time field and the 16-bit windows
  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] half_min_q, half_max_q, full_min_q, full_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_min_q <= HALF_MIN_RST;
      half_max_q <= HALF_MAX_RST;
      full_min_q <= FULL_MIN_RST;
      full_max_q <= FULL_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_HALF_MIN: half_min_q <= cfg_data_i;
        CFG_HALF_MAX: half_max_q <= cfg_data_i;
        CFG_FULL_MIN: full_min_q <= cfg_data_i;
        CFG_FULL_MAX: full_max_q <= cfg_data_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Command transfer and edge store
  // ---------------------------------------------------------------------------
  fsm_e state_q, state_d;

  logic rec_fire, eval_fire;
  assign rec_fire  = start && !busy && (cmd_i == CMD_RECORD);
  assign eval_fire = start && !busy && (cmd_i == CMD_EVAL);

  // edge count saturates at the last entry; further edges overwrite it
  logic [ADDR_W-1:0] edge_cnt_q, edge_cnt_d;
  logic [ADDR_W-1:0] eval_n_q;

  always_comb begin
    edge_cnt_d = edge_cnt_q;
    if (eval_fire) begin
      edge_cnt_d = '0;
    end else if (rec_fire && edge_cnt_q < ADDR_W'(COUNT_MAX)) begin
      edge_cnt_d = edge_cnt_q + ADDR_W'(1);
    end
  end

  mem_req_t             wr_req, rd_req;
  logic [TIME_BITS-1:0] wr_time;
  logic                 rd_level;
  logic [TIME_BITS-1:0] rd_time;

  assign wr_req.en   = rec_fire;
  assign wr_req.addr = edge_cnt_q;
  // first edge of a frame is the time origin
  assign wr_time     = (edge_cnt_q == '0) ? '0 : TIME_BITS'(edge_time_i);

  dbfd_edge_mem #(
    .TIME_BITS (TIME_BITS)
  ) u_edge_mem (
    .clk_i      (clk_i),
    .wr_req_i   (wr_req),
    .wr_level_i (edge_level_i),
    .wr_time_i  (wr_time),
    .rd_req_i   (rd_req),
    .rd_level_o (rd_level),
    .rd_time_o  (rd_time)
  );

  // ---------------------------------------------------------------------------
  // Walk over stored edges: read entry k, classify gap (k-1 -> k) when it returns.
  // The memory sees no write while busy, so reads never collide with writes.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]    rd_addr_q, rd_idx_q;
  logic                 rd_vld_q;
  logic                 prev_lvl_q;
  logic [TIME_BITS-1:0] prev_time_q;
  logic                 err_q;

  logic                 backward, in_short, in_long, gap_err;
  logic [TIME_BITS-1:0] gap;
  logic [CMP_W-1:0]     gap_x;
  logic                 pair_rd, last_rd;

  assign backward = rd_time < prev_time_q;
  assign gap      = rd_time - prev_time_q;
  assign gap_x    = CMP_W'(gap);
  // short window takes priority over long
  assign in_short = (gap_x >= CMP_W'(half_min_q)) && (gap_x <= CMP_W'(half_max_q));
  assign in_long  = (gap_x >= CMP_W'(full_min_q)) && (gap_x <= CMP_W'(full_max_q));
  assign gap_err  = backward || !(in_short || in_long);

  assign pair_rd  = rd_vld_q && (rd_idx_q != '0);
  assign last_rd  = rd_vld_q && (rd_idx_q == eval_n_q - ADDR_W'(1));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [1:0] app_n;
  logic       app_lvl;
  logic       fin;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (eval_fire) begin
          state_d = (edge_cnt_q < ADDR_W'(2)) ? FSM_DONE : FSM_WALK;
        end
      end
      FSM_WALK: begin
        if (last_rd) begin
          state_d = FSM_TAIL;
        end
      end
      FSM_TAIL: state_d = FSM_DONE;
      FSM_DONE: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    rd_req.en   = 1'b0;
    rd_req.addr = rd_addr_q;
    app_n       = 2'd0;
    app_lvl     = prev_lvl_q;
    fin         = 1'b0;
    unique case (state_q)
      FSM_IDLE: ;
      FSM_WALK: begin
        busy      = 1'b1;
        rd_req.en = rd_addr_q < eval_n_q;
        if (pair_rd && !gap_err) begin
          app_n = (!in_short) ? 2'd2 : 2'd1;
        end
      end
      FSM_TAIL: begin
        busy  = 1'b1;
        app_n = 2'd1;  // last edge always counts as one half-bit
      end
      FSM_DONE: begin
        busy = 1'b1;
        fin  = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Half-bit stream, filled MSB first; bits past the end are dropped
  // ---------------------------------------------------------------------------
  logic [HALF_BITS-1:0] stream_q, stream_d;
  logic [POS_W-1:0]     pos_q, pos_d;

  always_comb begin
    stream_d = stream_q;
    pos_d    = pos_q;
    if (eval_fire) begin
      stream_d = '0;
      pos_d    = '0;
    end else begin
      for (int j = 0; j < 2; j++) begin
        if (2'(j) < app_n && pos_d < POS_W'(HALF_BITS)) begin
          stream_d[POS_W'(HALF_BITS - 1) - pos_d] = app_lvl;
          pos_d = pos_d + POS_W'(1);
        end
      end
    end
  end

  logic              chk_ok;
  logic [BYTE_W-1:0] chk_byte;

  dbfd_frame_check u_frame_check (
    .stream_i (stream_q),
    .ok_o     (chk_ok),
    .byte_o   (chk_byte)
  );

  // ---------------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------------
  logic              res_vld_q;
  status_e           status_q, status_d;
  logic [BYTE_W-1:0] byte_q, byte_d;

  always_comb begin
    status_d = STS_INVALID;
    byte_d   = '0;
    if (eval_n_q == '0) begin
      status_d = STS_NONE;
    end else if (eval_n_q != ADDR_W'(1) && !err_q && chk_ok) begin
      status_d = STS_DATA;
      byte_d   = chk_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FSM_IDLE;
      edge_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      edge_cnt_q <= edge_cnt_d;
      rd_vld_q   <= rd_req.en;
      res_vld_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      eval_n_q  <= edge_cnt_q;
      rd_addr_q <= '0;
      err_q     <= 1'b0;
    end else begin
      if (rd_req.en) begin
        rd_addr_q <= rd_addr_q + ADDR_W'(1);
      end
      if (pair_rd && gap_err) begin
        err_q <= 1'b1;
      end
    end
    rd_idx_q <= rd_addr_q;
    if (rd_vld_q) begin
      prev_lvl_q  <= rd_level;
      prev_time_q <= rd_time;
    end
    stream_q <= stream_d;
    pos_q    <= pos_d;
    if (fin) begin
      status_q <= status_d;
      byte_q   <= byte_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign status_o       = status_q;
  assign answer_byte_o  = byte_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_cnt_q <= ADDR_W'(COUNT_MAX))
    else $error("edge count beyond store");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !wr_req.en)
    else $error("edge store written during evaluation");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != STS_DATA) |-> (answer_byte_o == '0))
    else $error("answer byte set without valid data");

  a_strobe_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == FSM_DONE))
    else $error("result strobe without completed evaluation");
`endif

endmodule

// ===== tb/tb_dali_backward_frame_decoder.sv =====
`timescale 1ns / 1ps

// Stimulus drives at the falling edge and samples at the rising edge.
// A local copy of the edge store and timing windows runs alongside the DUT.
// Every evaluate command queues the answer that the copy predicts, and the
// result monitor checks each strobe against the oldest queued answer.
module tb_dali_backward_frame_decoder;
  import dbfd_pkg::*;

  localparam int ITEM_TARGET    = 1800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;    // record commands never raise busy
  localparam int DRAIN_CYCLES   = 30;

  // Ways a generated frame departs from a clean Manchester answer
  typedef enum int {
    FLAW_NONE,
    FLAW_LEVEL,   // one edge reports the wrong level
    FLAW_GAP,     // one gap drawn from the whole timer range
    FLAW_DROP,    // one edge missing
    FLAW_EXTRA,   // trailing junk edges, may overflow the store
    FLAW_NOISE,   // random levels and raw timer values
    FLAW_SHORT    // zero or one edge before the evaluate
  } flaw_e;

  typedef struct packed {
    status_e          status;
    logic [BYTE_W-1:0] data;
  } pred_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   cmd_i;
  logic                   edge_level_i;
  logic [EDGE_TIME_W-1:0] edge_time_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   result_valid_o;
  logic [1:0]             status_o;
  logic [BYTE_W-1:0]      answer_byte_o;

  // Local copy of the decoder state
  logic              edge_lvl_mem [HALF_BITS];
  logic [15:0]       edge_time_mem [HALF_BITS];
  int                edges_held;
  logic [CFG_W-1:0]  win_half_lo;
  logic [CFG_W-1:0]  win_half_hi;
  logic [CFG_W-1:0]  win_full_lo;
  logic [CFG_W-1:0]  win_full_hi;

  pred_t answer_q [$];

  bit no_idle;
  int n_items;
  int n_mismatch;
  int n_settings;
  int n_data;
  int n_invalid;
  int n_empty;
  int idle_cycles;

  dali_backward_frame_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .edge_level_i   (edge_level_i),
    .edge_time_i    (edge_time_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .answer_byte_o  (answer_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Answer the decoder should give for the edges held right now.
  function automatic pred_t decode_answer();
    pred_t                a;
    logic [HALF_BITS-1:0] long_gap;
    logic [HALF_BITS-1:0] halves;   // bit HALF_BITS-1 is the first half-bit
    logic [DATA_BITS-1:0] word;
    logic [1:0]           pair;
    logic [2:0]           trio;
    int                   k;
    int                   pos;
    int                   gap;
    a.status = STS_INVALID;
    a.data   = '0;
    if (edges_held == 0) begin
      a.status = STS_NONE;
      return a;
    end
    if (edges_held == 1) return a;
    // gap classification; short window wins where the two overlap
    long_gap = '0;
    for (k = 0; k + 1 < edges_held; k++) begin
      if (edge_time_mem[k+1] < edge_time_mem[k]) return a;
      gap = int'(edge_time_mem[k+1]) - int'(edge_time_mem[k]);
      if (gap >= int'(win_half_lo) && gap <= int'(win_half_hi)) begin
        long_gap[k] = 1'b0;
      end else if (gap >= int'(win_full_lo) && gap <= int'(win_full_hi)) begin
        long_gap[k] = 1'b1;
      end else begin
        return a;
      end
    end
    // last edge always one half-bit, uncovered half-bits stay zero
    halves = '0;
    pos    = 0;
    for (k = 0; k < edges_held && pos < HALF_BITS; k++) begin
      halves[HALF_BITS-1-pos] = edge_lvl_mem[k];
      pos++;
      if (long_gap[k] && pos < HALF_BITS) begin
        halves[HALF_BITS-1-pos] = edge_lvl_mem[k];
        pos++;
      end
    end
    for (k = 0; k + 2 < HALF_BITS; k++) begin
      trio = halves[k +: 3];
      if (trio == 3'b000 || trio == 3'b111) return a;
    end
    word = '0;
    for (k = 0; k < HALF_BITS; k += 2) begin
      pair = halves[HALF_BITS-1-k -: 2];
      if (pair == 2'b00 || pair == 2'b11) return a;
      word = {word[DATA_BITS-2:0], pair == 2'b01};
    end
    if (!word[DATA_BITS-1]) return a;   // start bit missing
    a.status = STS_DATA;
    a.data   = word[BYTE_W-1:0];
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // One run's timer step: mostly in its window, at times on its edges; random if empty.
  function automatic int unsigned gap_for(input logic is_long);
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    int               r;
    lo = is_long ? win_full_lo : win_half_lo;
    hi = is_long ? win_full_hi : win_half_hi;
    r  = $urandom_range(99);
    if (lo > hi) return $urandom_range(16'hFFFF);
    if (r < 8) return lo;
    if (r < 16) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // One command transfer; the local store follows at the accepting edge.
  task automatic put_item(input cmd_e c, input logic lvl, input logic [15:0] t);
    int g;
    @(negedge clk_i);
    start        <= 1'b1;
    cmd_i        <= c;
    edge_level_i <= lvl;
    edge_time_i  <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_items++;
    if (c == CMD_EVAL) begin
      answer_q.push_back(decode_answer());
      case (answer_q[$].status)
        STS_NONE: n_empty++;
        STS_DATA: n_data++;
        default:  n_invalid++;
      endcase
      edges_held = 0;
    end else begin
      // store saturates: the last slot keeps getting overwritten
      edge_lvl_mem[edges_held]  = lvl;
      edge_time_mem[edges_held] = (edges_held == 0) ? 16'd0 : t;
      if (edges_held < COUNT_MAX) edges_held++;
    end
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // Drop start, wait for every answer, then give the last record time to land.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_cfg(input cfg_reg_e idx, input logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_HALF_MIN: win_half_lo = v;
      CFG_HALF_MAX: win_half_hi = v;
      CFG_FULL_MIN: win_full_lo = v;
      default:      win_full_hi = v;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_windows(input logic [CFG_W-1:0] hlo, input logic [CFG_W-1:0] hhi,
                             input logic [CFG_W-1:0] flo, input logic [CFG_W-1:0] fhi);
    settle();
    put_cfg(CFG_HALF_MIN, hlo);
    put_cfg(CFG_HALF_MAX, hhi);
    put_cfg(CFG_FULL_MIN, flo);
    put_cfg(CFG_FULL_MAX, fhi);
    n_settings++;
  endtask

  // Manchester-encode start bit plus byte into edges, damage it as asked, evaluate.
  task automatic send_frame(input logic [BYTE_W-1:0] data, input flaw_e flaw);
    logic [HALF_BITS-1:0] halves;
    logic [DATA_BITS-1:0] word;
    logic                 run_lvl [$];
    logic                 run_long [$];
    int                   i;
    int                   j;
    int                   bad_gap;
    int unsigned          stamp;
    logic [15:0]          t_item;
    word = {1'b1, data};
    for (j = 0; j < DATA_BITS; j++) begin
      halves[HALF_BITS-1-2*j] = ~word[DATA_BITS-1-j];
      halves[HALF_BITS-2-2*j] = word[DATA_BITS-1-j];
    end
    // one edge per run of equal half-bits; runs are one or two long
    i = HALF_BITS - 1;
    while (i >= 0) begin
      run_lvl.push_back(halves[i]);
      if (i > 0 && halves[i-1] == halves[i]) begin
        run_long.push_back(1'b1);
        i -= 2;
      end else begin
        run_long.push_back(1'b0);
        i -= 1;
      end
    end
    bad_gap = -1;
    case (flaw)
      FLAW_LEVEL: begin
        j = $urandom_range(run_lvl.size() - 1);
        run_lvl[j] = ~run_lvl[j];
      end
      FLAW_GAP: bad_gap = $urandom_range(run_lvl.size() - 2);
      FLAW_DROP: begin
        j = $urandom_range(run_lvl.size() - 1);
        run_lvl.delete(j);
        run_long.delete(j);
      end
      FLAW_EXTRA: begin
        repeat ($urandom_range(1, 8)) begin
          run_lvl.push_back($urandom_range(1));
          run_long.push_back($urandom_range(1));
        end
      end
      FLAW_NOISE, FLAW_SHORT: begin
        run_lvl.delete();
        run_long.delete();
        repeat ((flaw == FLAW_SHORT) ? $urandom_range(1) : $urandom_range(2, 22)) begin
          run_lvl.push_back($urandom_range(1));
          run_long.push_back($urandom_range(1));
        end
      end
      default: ;
    endcase
    // first edge time is don't-care: the decoder stores it as zero
    stamp = 0;
    for (j = 0; j < run_lvl.size(); j++) begin
      if (flaw == FLAW_NOISE || j == 0) t_item = $urandom_range(16'hFFFF);
      else t_item = stamp[15:0];
      put_item(CMD_RECORD, run_lvl[j], t_item);
      stamp += (j == bad_gap) ? $urandom_range(16'hFFFF) : gap_for(run_long[j]);
    end
    put_item(CMD_EVAL, $urandom_range(1), $urandom_range(16'hFFFF));
  endtask

  function automatic flaw_e pick_flaw();
    int r;
    r = $urandom_range(99);
    if (r < 60) return FLAW_NONE;
    if (r < 68) return FLAW_LEVEL;
    if (r < 76) return FLAW_GAP;
    if (r < 82) return FLAW_DROP;
    if (r < 90) return FLAW_EXTRA;
    if (r < 95) return FLAW_NOISE;
    return FLAW_SHORT;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_empty_and_lone_edge();
    put_item(CMD_EVAL, 1'b1, 16'hFFFF);        // nothing stored
    put_item(CMD_RECORD, 1'b0, 16'hFFFF);      // lone edge is invalid
    put_item(CMD_EVAL, 1'b0, 16'h0000);
  endtask

  task automatic test_clean_frame();
    send_frame(8'h55, FLAW_NONE);
  endtask

  task automatic test_timing_faults();
    // later edge earlier than the one before it
    put_item(CMD_RECORD, 1'b0, 16'd1234);
    put_item(CMD_RECORD, 1'b1, 16'd500);
    put_item(CMD_RECORD, 1'b0, 16'd100);
    put_item(CMD_EVAL, 1'b0, 16'd0);
    // gap falls between the half and full windows
    put_item(CMD_RECORD, 1'b0, 16'd0);
    put_item(CMD_RECORD, 1'b1, 16'd600);
    put_item(CMD_RECORD, 1'b0, 16'd1000);
    put_item(CMD_EVAL, 1'b1, 16'd0);
  endtask

  task automatic test_window_extremes();
    set_windows(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (6) send_frame($urandom_range(255), pick_flaw());
    set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (6) send_frame($urandom_range(255), pick_flaw());
    set_windows(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);  // every gap is short
    repeat (6) send_frame($urandom_range(255), pick_flaw());
    set_windows(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF);  // short window empty
    repeat (6) send_frame($urandom_range(255), pick_flaw());
  endtask

  task automatic test_random_traffic();
    int               mode;
    logic [CFG_W-1:0] hlo;
    logic [CFG_W-1:0] hhi;
    logic [CFG_W-1:0] flo;
    logic [CFG_W-1:0] fhi;
    set_windows(HALF_MIN_RST, HALF_MAX_RST, FULL_MIN_RST, FULL_MAX_RST);
    while (n_items < ITEM_TARGET) begin
      repeat (14) begin
        no_idle = ($urandom_range(4) == 0);
        send_frame($urandom_range(255), pick_flaw());
      end
      no_idle = 1'b0;
      mode = $urandom_range(99);
      if (mode < 45) begin
        // disjoint windows, the usual setup
        hlo = $urandom_range(100, 400);
        hhi = hlo + $urandom_range(250);
        flo = hhi + $urandom_range(1, 200);
        fhi = flo + $urandom_range(400);
      end else if (mode < 80) begin
        // windows that mostly overlap
        hlo = $urandom_range(500);
        hhi = hlo + $urandom_range(200, 600);
        flo = hlo + $urandom_range(300);
        fhi = flo + $urandom_range(800);
      end else begin
        hlo = $urandom_range(16'hFFFF);
        hhi = $urandom_range(16'hFFFF);
        flo = $urandom_range(16'hFFFF);
        fhi = $urandom_range(16'hFFFF);
      end
      set_windows(hlo, hhi, flo, fhi);
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    pred_t want;
    if (rst_ni && result_valid_o) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected answer status %0d byte 0x%02h", $time, status_o,
                 answer_byte_o);
        n_mismatch++;
      end else begin
        want = answer_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status,
                   status_o);
          n_mismatch++;
        end
        if (answer_byte_o !== want.data) begin
          $display("%0t: answer byte mismatch: expected 0x%02h, actual 0x%02h", $time,
                   want.data, answer_byte_o);
          n_mismatch++;
        end
      end
    end
  end

  // Watchdog: any command, config or result transfer restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("dali_backward_frame_decoder verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = CMD_RECORD;
    edge_level_i = 1'b0;
    edge_time_i  = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_HALF_MIN;
    cfg_data_i   = '0;
    no_idle      = 1'b0;
    n_items      = 0;
    n_mismatch   = 0;
    n_settings   = 0;
    n_data       = 0;
    n_invalid    = 0;
    n_empty      = 0;
    idle_cycles  = 0;
    edges_held   = 0;
    win_half_lo  = HALF_MIN_RST;
    win_half_hi  = HALF_MAX_RST;
    win_full_lo  = FULL_MIN_RST;
    win_full_hi  = FULL_MAX_RST;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_lone_edge();
    test_clean_frame();
    test_timing_faults();
    test_window_extremes();
    test_random_traffic();

    @(negedge clk_i);
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d commands, %0d window settings", n_items, n_settings);
    $display("answers: %0d data, %0d invalid, %0d empty", n_data, n_invalid, n_empty);
    if (n_mismatch == 0) begin
      $display("dali_backward_frame_decoder verification clean");
    end else begin
      $display("dali_backward_frame_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dbfd_pkg.sv
hw/rtl/dbfd_edge_mem.sv
hw/rtl/dbfd_frame_check.sv
hw/rtl/dali_backward_frame_decoder.sv
tb/tb_dali_backward_frame_decoder.sv
